/* rtl/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants of the running statistics accumulator
// Command/status structs between controller and datapath, register indexes,
// divider operand selects and arithmetic widths.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Arithmetic widths
  localparam int unsigned DIV_W      = 64;   // divider dividend/quotient
  localparam int unsigned DVS_W      = 16;   // divider divisor
  localparam int unsigned DIV_CNT_W  = 6;    // divider step counter
  localparam int unsigned RAD_W      = 64;   // square root radicand
  localparam int unsigned ROOT_W     = 32;   // square root result
  localparam int unsigned ROOT_CNT_W = 5;    // square root step counter
  localparam int unsigned OUT_W      = 192;  // packed result word

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_MIN_START = 2'd1;
  localparam logic [1:0] CFG_MAX_START = 2'd2;

  // Reset values of the start registers
  localparam logic [31:0] MIN_START_RST = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_START_RST = 32'hFFFF_0000;

  // Divider operand selects
  localparam logic [1:0] SEL_MEAN = 2'd0;  // |sum| / n
  localparam logic [1:0] SEL_STEP = 2'd1;  // |d| / n
  localparam logic [1:0] SEL_TERM = 2'd2;  // d2*(n-1) / n
  localparam logic [1:0] SEL_VAR  = 2'd3;  // q / (n-1)

  typedef struct packed {
    logic       clear;      // empty the statistics
    logic       first;      // first sample after clear
    logic       update;     // count/sum/min/max and deviation from mean
    logic       square;     // square the deviation
    logic       mul_lo;     // low partial product of d2*(n-1)
    logic       mul_hi;     // high partial product and sum
    logic       div_go;     // start divider on selected operands
    logic       div_take;   // store divider result
    logic [1:0] sel;        // divider operand select
    logic       sqrt_go;    // start square root
    logic       sqrt_take;  // store standard deviation
    logic       load_out;   // load output register
    logic       full;       // refused flag for the loaded word
  } rsa_cmd_t;

  typedef struct packed {
    logic enable;
    logic cnt_zero;
    logic cnt_full;
    logic div_done;
    logic sqrt_done;
  } rsa_sts_t;

endpackage

/* rtl/rsa_div.sv */
// ----------------------------------------------------------------------------
// rsa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [rsa_pkg::DIV_W-1:0]   dividend_i,
  input  logic [rsa_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [rsa_pkg::DIV_W-1:0]   quotient_o
);
  import rsa_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;

  logic [DVS_W:0]       trial;
  logic                 fits;
  logic [DVS_W:0]       diff;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    fits  = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // data
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/rsa_sqrt.sv */
// ----------------------------------------------------------------------------
// rsa_sqrt: iterative integer square root
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rsa_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [rsa_pkg::RAD_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [rsa_pkg::ROOT_W-1:0]  root_o
);
  import rsa_pkg::*;

  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W+1:0]     rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic                  run_q;
  logic                  done_q;

  logic [ROOT_W+1:0]     trial_rem;
  logic [ROOT_W+1:0]     trial;
  logic                  fits;

  // one digit step; remainder is below 2^32 before each shift
  always_comb begin
    trial_rem = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
    trial     = {root_q, 2'b01};
    fits      = (trial_rem >= trial);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // data
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? (trial_rem - trial) : trial_rem;
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/rsa_dp.sv */
// ----------------------------------------------------------------------------
// rsa_dp: statistics datapath
// Holds configuration, running state and the output word; owns the shared
// divider and the square root unit.
// ----------------------------------------------------------------------------
module rsa_dp #(
  parameter int unsigned MAX_COUNT = 65535
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsa_pkg::rsa_cmd_t           cmd_i,
  output rsa_pkg::rsa_sts_t           sts_o,
  input  logic [31:0]                 sample_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  output logic [rsa_pkg::OUT_W-1:0]   out_data_o,
  output logic                        out_full_o
);
  import rsa_pkg::*;

  // configuration
  logic               en_q;
  logic [31:0]        min_start_q;
  logic [31:0]        max_start_q;

  // running state
  logic [15:0]        cnt_q;
  logic signed [47:0] sum_q;
  logic signed [31:0] min_q;
  logic signed [31:0] max_q;
  logic [31:0]        mean_q;
  logic [31:0]        wm_q;
  logic [63:0]        dsum_q;
  logic [31:0]        dev_q;

  // work registers
  logic [31:0]        ad_q;
  logic               dneg_q;
  logic               sneg_q;
  logic [63:0]        sq_q;
  logic [39:0]        pl_q;
  logic [63:0]        prod_q;
  logic [63:0]        var_q;

  // output word
  logic [OUT_W-1:0]   out_q;
  logic               full_q;

  logic signed [31:0] x;
  logic signed [47:0] sum_new;
  logic [32:0]        d33;
  logic [32:0]        ad33;
  logic [47:0]        sum_mag;
  logic [15:0]        nm1;
  logic [39:0]        ph;
  logic [DIV_W-1:0]   div_a;
  logic [DVS_W-1:0]   div_b;
  logic [DIV_W-1:0]   quo;
  logic [31:0]        quo32;
  logic [64:0]        dsum_add;
  logic               div_done;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  root;

  // sample arithmetic
  always_comb begin
    x       = $signed(sample_i);
    sum_new = sum_q + 48'(x);
    d33     = {x[31], x} - {wm_q[31], wm_q};
    ad33    = d33[32] ? (33'd0 - d33) : d33;
    sum_mag = sum_q[47] ? (48'd0 - sum_q) : sum_q;
    nm1     = cnt_q - 16'd1;
    ph      = sq_q[63:40] * nm1;
    quo32   = quo[31:0];
    dsum_add = {1'b0, dsum_q} + {1'b0, quo};
  end

  // divider operand select
  always_comb begin
    div_b = cnt_q;
    case (cmd_i.sel)
      SEL_MEAN: div_a = {16'd0, sum_mag};
      SEL_STEP: div_a = {32'd0, ad_q};
      SEL_TERM: div_a = prod_q;
      SEL_VAR: begin
        div_a = dsum_q;
        div_b = nm1;
      end
      default:  div_a = '0;
    endcase
  end

  rsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  rsa_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.sqrt_go),
    .radicand_i ({var_q[47:0], 16'd0}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      min_start_q <= MIN_START_RST;
      max_start_q <= MAX_START_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:    en_q        <= cfg_data_i[0];
        CFG_MIN_START: min_start_q <= cfg_data_i;
        CFG_MAX_START: max_start_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      min_q  <= $signed(MIN_START_RST);
      max_q  <= $signed(MAX_START_RST);
      mean_q <= '0;
      wm_q   <= '0;
      dsum_q <= '0;
      dev_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        min_q  <= $signed(min_start_q);
        max_q  <= $signed(max_start_q);
        mean_q <= '0;
        wm_q   <= '0;
        dsum_q <= '0;
        dev_q  <= '0;
      end
      if (cmd_i.first || cmd_i.update) begin
        cnt_q <= cnt_q + 16'd1;
        sum_q <= sum_new;
        if (x < min_q) min_q <= x;
        if (x > max_q) max_q <= x;
      end
      if (cmd_i.first) begin
        mean_q <= sample_i;
        wm_q   <= sample_i;
        dsum_q <= '0;
        dev_q  <= '0;
      end
      if (cmd_i.div_take) begin
        case (cmd_i.sel)
          SEL_MEAN: mean_q <= sneg_q ? (32'd0 - quo32) : quo32;
          SEL_STEP: wm_q   <= wm_q + (dneg_q ? (32'd0 - quo32) : quo32);
          SEL_TERM: dsum_q <= dsum_add[64] ? '1 : dsum_add[63:0];
          default:  ;
        endcase
      end
      if (cmd_i.sqrt_take) begin
        dev_q <= (var_q[63:48] != 16'd0) ? '1 : root;
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ad_q   <= ad33[31:0];
      dneg_q <= d33[32];
      sneg_q <= sum_new[47];
    end
    if (cmd_i.square) sq_q <= ad_q * ad_q;
    if (cmd_i.mul_lo) pl_q <= sq_q[39:16] * nm1;
    if (cmd_i.mul_hi) prod_q <= {ph, 24'd0} + {24'd0, pl_q};
    if (cmd_i.div_take && cmd_i.sel == SEL_VAR) var_q <= quo;
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q  <= {dev_q, mean_q, max_q, min_q, sum_q, cnt_q};
      full_q <= cmd_i.full;
    end
  end

  assign sts_o.enable    = en_q;
  assign sts_o.cnt_zero  = (cnt_q == 16'd0);
  assign sts_o.cnt_full  = (cnt_q >= 16'(MAX_COUNT));
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;

  assign out_data_o = out_q;
  assign out_full_o = full_q;

endmodule

/* rtl/rsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rsa_ctrl: statistics controller
// Sequences one item at a time; an update runs through divides and square
// root, and the controller owns the input ready and output valid handshake.
// ----------------------------------------------------------------------------
module rsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rsa_pkg::rsa_sts_t   sts_i,
  output rsa_pkg::rsa_cmd_t   cmd_o
);
  import rsa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MEAN  = 4'd1;
  localparam logic [3:0] S_MEANW = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_STEPW = 4'd4;
  localparam logic [3:0] S_SQR   = 4'd5;
  localparam logic [3:0] S_MULA  = 4'd6;
  localparam logic [3:0] S_MULB  = 4'd7;
  localparam logic [3:0] S_TERM  = 4'd8;
  localparam logic [3:0] S_TERMW = 4'd9;
  localparam logic [3:0] S_VAR   = 4'd10;
  localparam logic [3:0] S_VARW  = 4'd11;
  localparam logic [3:0] S_ROOT  = 4'd12;
  localparam logic [3:0] S_ROOTW = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_q, state_d;
  logic       full_q, full_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    full_d  = full_q;
    cmd_o   = '0;
    cmd_o.full = full_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          full_d  = 1'b0;
          state_d = S_DONE;
          if (in_action_i) begin
            cmd_o.clear = 1'b1;
          end else if (sts_i.enable) begin
            if (sts_i.cnt_full) begin
              full_d = 1'b1;
            end else if (sts_i.cnt_zero) begin
              cmd_o.first = 1'b1;
            end else begin
              cmd_o.update = 1'b1;
              state_d      = S_MEAN;
            end
          end
        end
      end
      S_MEAN: begin
        cmd_o.sel    = SEL_MEAN;
        cmd_o.div_go = 1'b1;
        state_d      = S_MEANW;
      end
      S_MEANW: begin
        cmd_o.sel = SEL_MEAN;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.sel    = SEL_STEP;
        cmd_o.div_go = 1'b1;
        state_d      = S_STEPW;
      end
      S_STEPW: begin
        cmd_o.sel = SEL_STEP;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = S_MULA;
      end
      S_MULA: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_TERM;
      end
      S_TERM: begin
        cmd_o.sel    = SEL_TERM;
        cmd_o.div_go = 1'b1;
        state_d      = S_TERMW;
      end
      S_TERMW: begin
        cmd_o.sel = SEL_TERM;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_VAR;
        end
      end
      S_VAR: begin
        cmd_o.sel    = SEL_VAR;
        cmd_o.div_go = 1'b1;
        state_d      = S_VARW;
      end
      S_VARW: begin
        cmd_o.sel = SEL_VAR;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.sqrt_go = 1'b1;
        state_d       = S_ROOTW;
      end
      S_ROOTW: begin
        if (sts_i.sqrt_done) begin
          cmd_o.sqrt_take = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.load_out)   ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      full_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      full_q   <= full_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

/* rtl/running_statistics_accumulator.sv */
// ----------------------------------------------------------------------------
// running_statistics_accumulator: one-pass mean, variance and extremes
// Top level joining the controller and the statistics datapath.
// ----------------------------------------------------------------------------
// One word at a time: a clear, a disabled sample or a refused sample at the
// count limit goes from idle straight to the done state, which loads the output
// register once it is free; a sample that starts a run does the same. Any other
// sample runs four divides on the shared bit-serial divider (mean, mean step,
// deviation term, variance), a square, two partial products and a square root.
// The input is ready again once the result sits in the output register, so one
// result may wait there while the next word is being worked on.
module running_statistics_accumulator #(
  parameter int unsigned MAX_COUNT = 65535
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [31:0]                s_axis_tdata_i,   // [31:0] sample
  input  logic                       s_axis_tuser_i,   // [0] action (1 = clear)
  // result stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [15:0] count, [63:16] total, [95:64] smallest, [127:96] largest,
  // [159:128] average, [191:160] deviation
  output logic [rsa_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic                       m_axis_tuser_o,   // [0] full_res
  // configuration
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_data_i
);
  import rsa_pkg::*;

  rsa_cmd_t cmd;
  rsa_sts_t sts;

  rsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsa_dp #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (s_axis_tdata_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata_o),
    .out_full_o (m_axis_tuser_o)
  );

endmodule

/* rtl/rsa_chk.sv */
// ----------------------------------------------------------------------------
// rsa_chk: port checker for the running statistics accumulator
// Watches the top-level ports for word ordering and result consistency.
// ----------------------------------------------------------------------------
module rsa_chk #(
  parameter int unsigned MAX_COUNT = 65535
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [191:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  logic       in_hs;
  logic       out_hs;
  logic [2:0] pend_q;

  assign in_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;

  // words taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, in_hs} - {2'b00, out_hs};
    end
  end

  // a result waits until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped before taken");

  // every result belongs to a taken word, at most two in flight
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 3'd2) && (!m_axis_tvalid_o || pend_q != 3'd0))
    else $error("result words out of step with taken words");

  // a refused sample only at the count limit
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[15:0] == 16'(MAX_COUNT))
    else $error("full flag without count at limit");

  // no deviation with fewer than two samples
  a_dev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:1] == 15'd0)
      |-> m_axis_tdata_o[191:160] == 32'd0)
    else $error("nonzero deviation with count below two");

endmodule

bind running_statistics_accumulator rsa_chk #(.MAX_COUNT(MAX_COUNT)) u_rsa_chk (.*);
